// ===== src/ptc_pkg.sv =====
// shared types and constants for the page translation block with clock replacement
// no dependencies; imported by page_translate_clock_replace and its testbench
package ptc_pkg;

  // address split
  localparam int ADDR_BITS = 32;
  localparam int OFS_BITS  = 13;
  localparam int PAGE_BITS = ADDR_BITS - OFS_BITS;
  localparam int PAGES     = 1 << PAGE_BITS;

  // physical frames
  localparam int FRAMES     = 256;
  localparam int FRAME_BITS = $clog2(FRAMES);
  localparam int CNT_BITS   = $clog2(FRAMES + 1);

  // field widths of the result and of the config data
  localparam int PHYS_BITS  = 21;
  localparam int STAT_BITS  = 2;
  localparam int FUSED_BITS = 8;
  localparam int CFG_BITS   = 9;

  // register reset value
  localparam logic [CFG_BITS-1:0] NUM_FRAMES_RST = CFG_BITS'(FRAMES);

  // status codes
  localparam logic [STAT_BITS-1:0] STAT_HIT     = 2'd0;
  localparam logic [STAT_BITS-1:0] STAT_FAULT   = 2'd1;
  localparam logic [STAT_BITS-1:0] STAT_INVALID = 2'd2;

  // frame table entry: reference bit and owning page
  typedef struct packed {
    logic                 refd;
    logic [PAGE_BITS-1:0] owner;
  } frame_entry_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAP,
    ST_OWN,
    ST_SWEEP
  } ptc_state_t;

endpackage

// ===== src/ptc_ram.sv =====
// generic simple dual-port ram, one write port, one registered read port
// no dependencies; read during write to the same entry returns the old data
module ptc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/page_translate_clock_replace.sv =====
// page translation with demand paging and second-chance clock replacement
// depends on ptc_pkg and ptc_ram (page table and frame table memories)
//
//  channel   handshake            payload
//  request   start / busy         virt_addr
//  result    done (1-cycle pulse) phys_addr, status, evicted, evicted_page, frame_used
//  config    cfg_valid/cfg_ready  cfg_data (num_frames)
//
// invalid page: the result is registered straight from idle, busy never rises.
// hit or fault into a free frame: the request passes the map and own states,
// then the result is registered. fault with eviction: the sweep state then
// passes each active frame (num_frames clamped to 1..256) at most once before it
// evicts; each step is one read of the frame table port.
// no clearing pass after reset: frames fill in order, a fill count marks the busy
// ones, and a page table entry counts only if its frame's owner names the page.
// the receiver cannot stall; results sit on the ports for the done cycle.
module page_translate_clock_replace
  import ptc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [ADDR_BITS-1:0]  virt_addr,
  output logic                  done,
  output logic [PHYS_BITS-1:0]  phys_addr,
  output logic [STAT_BITS-1:0]  status,
  output logic                  evicted,
  output logic [PAGE_BITS-1:0]  evicted_page,
  output logic [FUSED_BITS-1:0] frame_used,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_BITS-1:0]   cfg_data
);

  // registers
  ptc_state_t              state, state_next;
  logic [CFG_BITS-1:0]     num_frames;
  logic [CNT_BITS-1:0]     fill, fill_next;
  logic [FRAME_BITS-1:0]   hand, hand_next;
  logic [CNT_BITS-1:0]     sweep_cnt, sweep_cnt_next;
  logic [FRAME_BITS-1:0]   frame_q, frame_q_next;
  logic [PAGE_BITS-1:0]    page_q, page_q_next;
  logic [OFS_BITS-1:0]     off_q, off_q_next;
  logic                    done_next;
  logic [PHYS_BITS-1:0]    phys_addr_next;
  logic [STAT_BITS-1:0]    status_next;
  logic                    evicted_next;
  logic [PAGE_BITS-1:0]    evicted_page_next;
  logic [FUSED_BITS-1:0]   frame_used_next;

  // memory ports
  logic                    pm_we;
  logic [PAGE_BITS-1:0]    pm_waddr, pm_raddr;
  logic [FRAME_BITS-1:0]   pm_wdata, pm_rdata;
  logic                    fr_we;
  logic [FRAME_BITS-1:0]   fr_waddr, fr_raddr;
  frame_entry_t            fr_wdata, fr_rdata;

  // decoded values
  logic [PAGE_BITS-1:0]    page_in;
  logic [OFS_BITS-1:0]     offset_in;
  logic                    invalid_in;
  logic [CNT_BITS-1:0]     n_act;
  logic                    hit;
  logic [FRAME_BITS-1:0]   hand_eff;
  logic [CNT_BITS-1:0]     hand_inc;
  logic [FRAME_BITS-1:0]   hand_step;
  logic [FRAME_BITS-1:0]   fill_frame;

  // page table: page -> frame, entries undefined until written
  ptc_ram #(
    .WIDTH (FRAME_BITS),
    .DEPTH (PAGES)
  ) u_page_map (
    .clk   (clk),
    .we    (pm_we),
    .waddr (pm_waddr),
    .wdata (pm_wdata),
    .raddr (pm_raddr),
    .rdata (pm_rdata)
  );

  // frame table: reference bit and owning page per frame
  ptc_ram #(
    .WIDTH ($bits(frame_entry_t)),
    .DEPTH (FRAMES)
  ) u_frame_tab (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .raddr (fr_raddr),
    .rdata (fr_rdata)
  );

  // request decode
  assign page_in    = virt_addr[ADDR_BITS-1:OFS_BITS];
  assign offset_in  = virt_addr[OFS_BITS-1:0];
  assign invalid_in = (page_in == '0) || (page_in == '1);

  // active frame count, clamped to 1..FRAMES
  always_comb begin
    if (num_frames == '0) begin
      n_act = CNT_BITS'(1);
    end else if (CNT_BITS'(num_frames) > CNT_BITS'(FRAMES)) begin
      n_act = CNT_BITS'(FRAMES);
    end else begin
      n_act = CNT_BITS'(num_frames);
    end
  end

  // a mapping counts only when its frame is loaded and owned by this page
  assign hit = ({1'b0, frame_q} < fill) && (fr_rdata.owner == page_q);

  // clock hand helpers
  assign hand_eff   = ({1'b0, hand} >= n_act) ? '0 : hand;
  assign hand_inc   = {1'b0, hand} + CNT_BITS'(1);
  assign hand_step  = (hand_inc == n_act) ? '0 : hand_inc[FRAME_BITS-1:0];
  assign fill_frame = fill[FRAME_BITS-1:0];

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // next state, memory controls and result
  always_comb begin
    state_next        = state;
    fill_next         = fill;
    hand_next         = hand;
    sweep_cnt_next    = sweep_cnt;
    frame_q_next      = frame_q;
    page_q_next       = page_q;
    off_q_next        = off_q;
    done_next         = 1'b0;
    phys_addr_next    = phys_addr;
    status_next       = status;
    evicted_next      = evicted;
    evicted_page_next = evicted_page;
    frame_used_next   = frame_used;
    pm_raddr          = page_in;
    pm_we             = 1'b0;
    pm_waddr          = page_q;
    pm_wdata          = frame_q;
    fr_raddr          = pm_rdata;
    fr_we             = 1'b0;
    fr_waddr          = frame_q;
    fr_wdata          = '{refd: 1'b0, owner: page_q};
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          page_q_next = page_in;
          off_q_next  = offset_in;
          if (invalid_in) begin
            done_next         = 1'b1;
            phys_addr_next    = '0;
            status_next       = STAT_INVALID;
            evicted_next      = 1'b0;
            evicted_page_next = '0;
            frame_used_next   = '0;
          end else begin
            state_next = ST_MAP;
          end
        end
      end
      ST_MAP: begin
        // page table data is back, fetch the frame entry
        frame_q_next = pm_rdata;
        fr_raddr     = pm_rdata;
        state_next   = ST_OWN;
      end
      ST_OWN: begin
        if (hit) begin
          // hit: set the reference bit
          fr_we             = 1'b1;
          fr_wdata          = '{refd: 1'b1, owner: page_q};
          done_next         = 1'b1;
          phys_addr_next    = PHYS_BITS'({frame_q, off_q});
          status_next       = STAT_HIT;
          evicted_next      = 1'b0;
          evicted_page_next = '0;
          frame_used_next   = FUSED_BITS'(frame_q);
          state_next        = ST_IDLE;
        end else if (fill < n_act) begin
          // fault into the lowest free frame
          fr_we             = 1'b1;
          fr_waddr          = fill_frame;
          pm_we             = 1'b1;
          pm_wdata          = fill_frame;
          fill_next         = fill + CNT_BITS'(1);
          done_next         = 1'b1;
          phys_addr_next    = PHYS_BITS'({fill_frame, off_q});
          status_next       = STAT_FAULT;
          evicted_next      = 1'b0;
          evicted_page_next = '0;
          frame_used_next   = FUSED_BITS'(fill_frame);
          state_next        = ST_IDLE;
        end else begin
          // no free frame: start the clock sweep
          hand_next      = hand_eff;
          sweep_cnt_next = '0;
          fr_raddr       = hand_eff;
          state_next     = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        fr_waddr = hand;
        fr_we    = 1'b1;
        if (fr_rdata.refd && (sweep_cnt != n_act)) begin
          // second chance: clear the bit and move on
          fr_wdata       = '{refd: 1'b0, owner: fr_rdata.owner};
          hand_next      = hand_step;
          sweep_cnt_next = sweep_cnt + CNT_BITS'(1);
          fr_raddr       = hand_step;
        end else begin
          // evict the frame under the hand and load the page
          pm_we             = 1'b1;
          pm_wdata          = hand;
          hand_next         = hand_step;
          done_next         = 1'b1;
          phys_addr_next    = PHYS_BITS'({hand, off_q});
          status_next       = STAT_FAULT;
          evicted_next      = 1'b1;
          evicted_page_next = fr_rdata.owner;
          frame_used_next   = FUSED_BITS'(hand);
          state_next        = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      num_frames <= NUM_FRAMES_RST;
      fill       <= '0;
      hand       <= '0;
      sweep_cnt  <= '0;
      done       <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      hand      <= hand_next;
      sweep_cnt <= sweep_cnt_next;
      done      <= done_next;
      if (cfg_valid && cfg_ready) begin
        num_frames <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    frame_q      <= frame_q_next;
    page_q       <= page_q_next;
    off_q        <= off_q_next;
    phys_addr    <= phys_addr_next;
    status       <= status_next;
    evicted      <= evicted_next;
    evicted_page <= evicted_page_next;
    frame_used   <= frame_used_next;
  end

  // fill count never passes the frame count
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_BITS'(FRAMES))
    else $error("fill count out of range");

  // a result only follows a request in flight
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result without request");

  // the sweep visits each active frame at most once before evicting
  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> (sweep_cnt <= n_act))
    else $error("sweep ran past the active frames");

  // a fault into a free frame takes exactly one more frame
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OWN && !hit && fill < n_act) |=> (fill == $past(fill) + CNT_BITS'(1)))
    else $error("fill count did not advance");

  // after an eviction the hand points inside the active frames
  a_hand_range: assert property (@(posedge clk) disable iff (rst)
    (done && evicted) |-> ({1'b0, hand} < n_act))
    else $error("clock hand out of range after eviction");

endmodule

// ===== test/page_translate_clock_replace_tb.sv =====
`timescale 1ns / 1ps
// testbench for page_translate_clock_replace: directed and random address streams
// checked against an in-bench translation predictor; depends on ptc_pkg and the rtl
module page_translate_clock_replace_tb;
  import ptc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PRINT_LIMIT = 40;

  // expected translation of one request
  typedef struct packed {
    logic [PHYS_BITS-1:0]  phys;
    logic [STAT_BITS-1:0]  stat;
    logic                  ev;
    logic [PAGE_BITS-1:0]  ev_page;
    logic [FUSED_BITS-1:0] frame;
  } xlate_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [ADDR_BITS-1:0]  virt_addr = '0;
  logic                  done;
  logic [PHYS_BITS-1:0]  phys_addr;
  logic [STAT_BITS-1:0]  status;
  logic                  evicted;
  logic [PAGE_BITS-1:0]  evicted_page;
  logic [FUSED_BITS-1:0] frame_used;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_BITS-1:0]   cfg_data = '0;

  // predictor state
  int unsigned          frame_of_page [int unsigned];
  logic [PAGE_BITS-1:0] frame_owner [FRAMES];
  bit                   frame_taken [FRAMES];
  bit                   frame_refd [FRAMES];
  int unsigned          hand = 0;
  logic [CFG_BITS-1:0]  frame_count = NUM_FRAMES_RST;

  xlate_result_t pending_translations [$];
  int unsigned   page_pool [$];
  int unsigned   mismatch_count = 0;
  int unsigned   stalled_cycles = 0;
  int unsigned   sender_idle_pct = 0;

  page_translate_clock_replace dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .virt_addr    (virt_addr),
    .done         (done),
    .phys_addr    (phys_addr),
    .status       (status),
    .evicted      (evicted),
    .evicted_page (evicted_page),
    .frame_used   (frame_used),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // frames that replacement may choose
  function automatic int unsigned active_frames();
    int unsigned n;
    n = frame_count;
    if (n == 0) n = 1;
    if (n > FRAMES) n = FRAMES;
    return n;
  endfunction

  // translate one address and update the paging state
  function automatic xlate_result_t translate(input logic [ADDR_BITS-1:0] addr);
    xlate_result_t r;
    int unsigned   page;
    int unsigned   f;
    int unsigned   n;
    bit            placed;
    page = addr >> OFS_BITS;
    r = '0;
    if (page == 0 || page == PAGES - 1) begin
      r.stat = STAT_INVALID;
      return r;
    end
    f = 0;
    if (frame_of_page.exists(page)) begin
      f = frame_of_page[page];
      frame_refd[f] = 1'b1;
      r.stat = STAT_HIT;
    end else begin
      r.stat = STAT_FAULT;
      n = active_frames();
      placed = 1'b0;
      // lowest free frame first
      for (int unsigned i = 0; i < n && !placed; i++) begin
        if (!frame_taken[i]) begin
          f = i;
          placed = 1'b1;
        end
      end
      // second-chance sweep from the hand
      if (!placed) begin
        if (hand >= n) hand = 0;
        for (int unsigned k = 0; k < n && frame_refd[hand]; k++) begin
          frame_refd[hand] = 1'b0;
          hand = (hand + 1) % n;
        end
        f = hand;
        r.ev = 1'b1;
        r.ev_page = frame_owner[f];
        frame_of_page.delete(int'(frame_owner[f]));
        hand = (hand + 1) % n;
      end
      frame_owner[f] = PAGE_BITS'(page);
      frame_taken[f] = 1'b1;
      frame_refd[f] = 1'b0;
      frame_of_page[page] = f;
    end
    r.phys = PHYS_BITS'((f << OFS_BITS) | (addr & ((1 << OFS_BITS) - 1)));
    r.frame = FUSED_BITS'(f);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_LIMIT) $display("mismatch at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // record accepted requests and register writes, check each result
  always @(posedge clk) begin
    xlate_result_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) frame_count = cfg_data;
      if (start && !busy) pending_translations.push_back(translate(virt_addr));
      if (done) begin
        if (pending_translations.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = pending_translations.pop_front();
          if (phys_addr !== want.phys)
            report_mismatch($sformatf("phys_addr %h, wanted %h", phys_addr, want.phys));
          if (status !== want.stat)
            report_mismatch($sformatf("status %0d, wanted %0d", status, want.stat));
          if (evicted !== want.ev)
            report_mismatch($sformatf("evicted %b, wanted %b", evicted, want.ev));
          if (evicted_page !== want.ev_page)
            report_mismatch($sformatf("evicted_page %h, wanted %h",
                                      evicted_page, want.ev_page));
          if (frame_used !== want.frame)
            report_mismatch($sformatf("frame_used %0d, wanted %0d", frame_used, want.frame));
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // send one request, sometimes after a random gap; start stays high on return
  task automatic send_request(input logic [ADDR_BITS-1:0] addr);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      virt_addr <= $urandom;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    virt_addr <= addr;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // stop sending and wait for every outstanding result
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_translations.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_frame_count(input logic [CFG_BITS-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic fill_pool(input int unsigned count);
    page_pool.delete();
    repeat (count) page_pool.push_back($urandom_range(1, PAGES - 2));
  endtask

  // mostly pool pages, a few invalid or arbitrary pages; random offset
  function automatic logic [ADDR_BITS-1:0] pool_address();
    logic [PAGE_BITS-1:0] page;
    int unsigned          roll;
    roll = $urandom_range(99);
    if (roll < 3) page = '0;
    else if (roll < 6) page = '1;
    else if (roll < 9) page = PAGE_BITS'($urandom);
    else page = PAGE_BITS'(page_pool[$urandom_range(page_pool.size() - 1)]);
    return {page, OFS_BITS'($urandom)};
  endfunction

  // invalid pages, offset extremes, hits, lowered and out-of-range frame counts
  task automatic test_directed_translation();
    send_request(32'h0000_0000);
    send_request(32'h0000_1FFF);
    send_request(32'hFFFF_E000);
    send_request(32'hFFFF_FFFF);
    send_request(32'h0000_2000);
    send_request(32'h0000_3FFF);
    send_request(32'hFFFF_DFFF);
    send_request(32'hAAAA_A555);
    send_request(32'h5555_5AAA);
    send_request(32'hFFFF_C000);
    // one frame: every fault evicts frame 0, higher frames still hit
    write_frame_count(9'd1);
    send_request(32'h0001_0000);
    send_request(32'h0000_2000);
    send_request(32'h5555_5AAA);
    // zero behaves as one
    write_frame_count(9'd0);
    send_request(32'h0001_0010);
    send_request(32'hFFFF_DFFF);
    // sweep over four frames, then shrink so the hand wraps
    write_frame_count(9'd4);
    send_request(32'h0002_0000);
    send_request(32'h0003_0000);
    send_request(32'h0004_0000);
    write_frame_count(9'd2);
    send_request(32'h0005_0000);
    // above the frame count limit
    write_frame_count(9'd511);
    send_request(32'h0006_1234);
    send_request(32'h0006_0000);
  endtask

  // small frame pools with a working set a little larger than the pool
  task automatic test_small_frame_pools();
    int unsigned n;
    for (int s = 0; s < 4; s++) begin
      n = (s == 0) ? 1 : $urandom_range(2, 16);
      write_frame_count(CFG_BITS'(n));
      fill_pool(n + $urandom_range(1, 8));
      repeat (30) send_request(pool_address());
    end
  endtask

  // all frames: fill every frame, then random reuse to force full sweeps
  task automatic test_full_frame_pool();
    write_frame_count(9'd256);
    fill_pool(264);
    foreach (page_pool[i]) send_request({PAGE_BITS'(page_pool[i]), OFS_BITS'($urandom)});
    repeat (50) send_request(pool_address());
  endtask

  // changing frame counts over resident and new pages
  task automatic test_mixed_settings();
    int unsigned n;
    for (int s = 0; s < 4; s++) begin
      n = (s == 3) ? $urandom_range(257, 511) : $urandom_range(1, 256);
      write_frame_count(CFG_BITS'(n));
      fill_pool(12);
      for (int i = 0; i < FRAMES; i++)
        if (frame_taken[i] && $urandom_range(7) == 0) page_pool.push_back(frame_owner[i]);
      repeat (20) send_request(pool_address());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    sender_idle_pct = 35;
    test_directed_translation();
    test_small_frame_pools();
    sender_idle_pct = 65;
    test_full_frame_pool();
    sender_idle_pct = 0;
    test_mixed_settings();
    settle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
